>>> rtl/core/bth_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
// Used by the controller and the top level; depends on nothing else.
`timescale 1ns / 1ps

package bth_pkg;

    // Request kinds carried on the input stream.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Tag layout: block size in the upper bits, allocated flag in bit 0.
    localparam logic [31:0] SIZE_MASK  = 32'hFFFF_FFF8;
    localparam logic [31:0] TAG_ALLOC  = 32'h0000_0001;
    localparam logic [31:0] MIN_BLOCK  = 32'd16;
    localparam logic [31:0] LIST_START = 32'd8;
    localparam logic [31:0] PROLOGUE   = 32'd9;

    // Reset value of the heap limit register.
    localparam logic [16:0] LIMIT_RESET = 17'h1_0000;

    // One request as it enters the controller.
    typedef struct packed {
        logic        req_type;
        logic [16:0] req_size;
        logic [15:0] block_addr;
    } t_req;

    // One result as it leaves the controller.
    typedef struct packed {
        logic        granted;
        logic [15:0] result_addr;
    } t_result;

endpackage

>>> rtl/core/bth_heap_ram.sv
// Word store of the heap: one write port and one registered read port.
// Stand-alone; instantiated by the top level.
`timescale 1ns / 1ps

module bth_heap_ram #(
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [(1 << ADDR_W)];
    logic [31:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bth_ctrl.sv
// Sequencer of the allocator: clearing pass, next-fit walk, split, growth,
// free and coalescing, all as read-modify-write steps on the heap store.
// Depends on bth_pkg; drives the ports of bth_heap_ram.
`timescale 1ns / 1ps

module bth_ctrl #(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096,
    parameter int ADDR_W      = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [16:0]           i_limit,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  bth_pkg::t_req         i_req,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output bth_pkg::t_result      o_res,
    output logic                  o_mem_we,
    output logic [ADDR_W-1:0]     o_mem_waddr,
    output logic [31:0]           o_mem_wdata,
    output logic [ADDR_W-1:0]     o_mem_raddr,
    input  logic [31:0]           i_mem_rdata
);

    // Sizes that follow from the parameters.
    localparam int CHUNK_SZ   = ((CHUNK_BYTES + 7) / 8) * 8;
    localparam int CAP0       = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam bit INIT_OK    = (CHUNK_SZ <= CAP0) && (CAP0 - CHUNK_SZ >= 16);
    localparam int BRK0       = INIT_OK ? 16 + CHUNK_SZ : 16;
    localparam int ROVER0     = INIT_OK ? 16 : 8;
    localparam int FTR0_W     = INIT_OK ? (CHUNK_SZ + 8) / 4 : 0;
    localparam int EPI0_W     = INIT_OK ? (CHUNK_SZ + 12) / 4 : 0;
    localparam int WALK_LIMIT = HEAP_BYTES / 8 + 2;
    localparam int CNT_W      = $clog2(WALK_LIMIT + 1);

    // Sequencer states.
    localparam logic [5:0] ST_INIT  = 6'd0;
    localparam logic [5:0] ST_IDLE  = 6'd1;
    localparam logic [5:0] ST_FR_0  = 6'd2;
    localparam logic [5:0] ST_FR_1  = 6'd3;
    localparam logic [5:0] ST_FR_2  = 6'd4;
    localparam logic [5:0] ST_MG_0  = 6'd5;
    localparam logic [5:0] ST_MG_1  = 6'd6;
    localparam logic [5:0] ST_MG_2  = 6'd7;
    localparam logic [5:0] ST_MG_3  = 6'd8;
    localparam logic [5:0] ST_MG_4  = 6'd9;
    localparam logic [5:0] ST_MG_5  = 6'd10;
    localparam logic [5:0] ST_MG_6  = 6'd11;
    localparam logic [5:0] ST_MA_1  = 6'd12;
    localparam logic [5:0] ST_MA_2  = 6'd13;
    localparam logic [5:0] ST_MA_3  = 6'd14;
    localparam logic [5:0] ST_MB_1  = 6'd15;
    localparam logic [5:0] ST_MB_2  = 6'd16;
    localparam logic [5:0] ST_MC_1  = 6'd17;
    localparam logic [5:0] ST_MC_2  = 6'd18;
    localparam logic [5:0] ST_MC_3  = 6'd19;
    localparam logic [5:0] ST_MD_1  = 6'd20;
    localparam logic [5:0] ST_MD_2  = 6'd21;
    localparam logic [5:0] ST_MD_3  = 6'd22;
    localparam logic [5:0] ST_MD_4  = 6'd23;
    localparam logic [5:0] ST_MD_5  = 6'd24;
    localparam logic [5:0] ST_MD_6  = 6'd25;
    localparam logic [5:0] ST_MD_7  = 6'd26;
    localparam logic [5:0] ST_MP_0  = 6'd27;
    localparam logic [5:0] ST_MP_1  = 6'd28;
    localparam logic [5:0] ST_MG_DN = 6'd29;
    localparam logic [5:0] ST_S1_0  = 6'd30;
    localparam logic [5:0] ST_S1_1  = 6'd31;
    localparam logic [5:0] ST_S1_2  = 6'd32;
    localparam logic [5:0] ST_S2_0  = 6'd33;
    localparam logic [5:0] ST_S2_1  = 6'd34;
    localparam logic [5:0] ST_S2_2  = 6'd35;
    localparam logic [5:0] ST_GR_0  = 6'd36;
    localparam logic [5:0] ST_GR_1  = 6'd37;
    localparam logic [5:0] ST_GR_2  = 6'd38;
    localparam logic [5:0] ST_GR_3  = 6'd39;
    localparam logic [5:0] ST_PL_0  = 6'd40;
    localparam logic [5:0] ST_PL_1  = 6'd41;
    localparam logic [5:0] ST_PL_2  = 6'd42;
    localparam logic [5:0] ST_PL_3  = 6'd43;
    localparam logic [5:0] ST_PL_4  = 6'd44;
    localparam logic [5:0] ST_PL_5  = 6'd45;
    localparam logic [5:0] ST_RES   = 6'd46;

    logic [5:0]        r_state, n_state;
    logic [31:0]       r_bp, n_bp;
    logic [31:0]       r_t, n_t;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_asize, n_asize;
    logic [CNT_W-1:0]  r_n, n_n;
    logic              r_pa, n_pa;
    logic              r_na, n_na;
    logic              r_free, n_free;
    logic [31:0]       r_rover, n_rover;
    logic [31:0]       r_brk, n_brk;
    bth_pkg::t_result  r_res, n_res;
    logic [ADDR_W-1:0] r_clr, n_clr;

    logic [31:0] w_d;
    logic        w_a;
    logic [31:0] w_raddr;
    logic [31:0] w_waddr;
    logic [31:0] w_wdata;
    logic        w_we;
    logic [31:0] w_init;
    logic [31:0] w_req_ext;
    logic [31:0] w_limit;
    logic [31:0] w_grow;
    logic [31:0] w_sum;
    logic [31:0] w_tnext;
    logic        w_walk_end;

    assign w_d = i_mem_rdata & bth_pkg::SIZE_MASK;
    assign w_a = i_mem_rdata[0];

    // Reset image of the store: prologue, one free chunk when it fits, and the epilogue.
    always_comb begin
        w_init = 32'd0;
        if (r_clr == ADDR_W'(1) || r_clr == ADDR_W'(2)) begin
            w_init = bth_pkg::PROLOGUE;
        end else if (r_clr == ADDR_W'(3)) begin
            w_init = INIT_OK ? 32'(CHUNK_SZ) : bth_pkg::TAG_ALLOC;
        end else if (INIT_OK && r_clr == ADDR_W'(FTR0_W)) begin
            w_init = 32'(CHUNK_SZ);
        end else if (INIT_OK && r_clr == ADDR_W'(EPI0_W)) begin
            w_init = bth_pkg::TAG_ALLOC;
        end
    end

    // Effective limit, capped at the store size.
    assign w_limit = (32'(i_limit) < 32'(HEAP_BYTES)) ? 32'(i_limit) : 32'(HEAP_BYTES);
    assign w_grow  = (r_asize > 32'(CHUNK_SZ)) ? r_asize : 32'(CHUNK_SZ);
    assign w_req_ext = 32'(i_req.req_size);
    assign w_walk_end = (r_n >= CNT_W'(WALK_LIMIT));

    // Next-state and memory-port logic.
    always_comb begin
        n_state = r_state;
        n_bp    = r_bp;
        n_t     = r_t;
        n_size  = r_size;
        n_asize = r_asize;
        n_n     = r_n;
        n_pa    = r_pa;
        n_na    = r_na;
        n_free  = r_free;
        n_rover = r_rover;
        n_brk   = r_brk;
        n_res   = r_res;
        n_clr   = r_clr;
        w_raddr = 32'd0;
        w_waddr = 32'd0;
        w_wdata = 32'd0;
        w_we    = 1'b0;
        w_sum   = r_size + w_d;
        w_tnext = r_t + w_d;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            // Clearing pass over the whole store.
            ST_INIT: begin
                w_we    = 1'b1;
                w_wdata = w_init;
                n_clr   = r_clr + ADDR_W'(1);
                if (r_clr == {ADDR_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_free = (i_req.req_type == bth_pkg::REQ_FREE);
                    n_bp   = 32'(i_req.block_addr);
                    if (i_req.req_type == bth_pkg::REQ_FREE) begin
                        n_state = ST_FR_0;
                    end else if (i_req.req_size == 17'd0) begin
                        n_res   = '0;
                        n_state = ST_RES;
                    end else begin
                        if (i_req.req_size <= 17'd8) begin
                            n_asize = bth_pkg::MIN_BLOCK;
                        end else begin
                            n_asize = (w_req_ext + 32'd15) & bth_pkg::SIZE_MASK;
                        end
                        n_state = ST_S1_0;
                    end
                end
            end
            // Free: rewrite both tags with the allocated flag cleared.
            ST_FR_0: begin
                w_raddr = r_bp - 32'd4;
                n_state = ST_FR_1;
            end
            ST_FR_1: begin
                w_we    = 1'b1;
                w_waddr = r_bp - 32'd4;
                w_wdata = w_d;
                n_size  = w_d;
                n_state = ST_FR_2;
            end
            ST_FR_2: begin
                w_we    = 1'b1;
                w_waddr = r_bp + r_size - 32'd8;
                w_wdata = r_size;
                n_state = ST_MG_0;
            end
            // Coalescing: gather the flags of both neighbors.
            ST_MG_0: begin
                w_raddr = r_bp - 32'd8;
                n_state = ST_MG_1;
            end
            ST_MG_1: begin
                n_t     = r_bp - w_d;
                w_raddr = r_bp - w_d - 32'd4;
                n_state = ST_MG_2;
            end
            ST_MG_2: begin
                w_raddr = w_tnext - 32'd8;
                n_state = ST_MG_3;
            end
            ST_MG_3: begin
                n_pa    = w_a;
                w_raddr = r_bp - 32'd4;
                n_state = ST_MG_4;
            end
            ST_MG_4: begin
                n_t     = r_bp + w_d;
                w_raddr = r_bp + w_d - 32'd4;
                n_state = ST_MG_5;
            end
            ST_MG_5: begin
                n_na    = w_a;
                w_raddr = r_bp - 32'd4;
                n_state = ST_MG_6;
            end
            ST_MG_6: begin
                n_size = w_d;
                if (r_pa && r_na) begin
                    n_state = ST_MG_DN;
                end else if (r_pa) begin
                    w_raddr = r_bp - 32'd4;
                    n_state = ST_MA_1;
                end else begin
                    w_raddr = r_bp - 32'd8;
                    n_state = ST_MB_1;
                end
            end
            // Merge with the following block only.
            ST_MA_1: begin
                w_raddr = r_bp + w_d - 32'd4;
                n_state = ST_MA_2;
            end
            ST_MA_2: begin
                w_we    = 1'b1;
                w_waddr = r_bp - 32'd4;
                w_wdata = w_sum;
                n_size  = w_sum;
                n_state = ST_MA_3;
            end
            ST_MA_3: begin
                w_we    = 1'b1;
                w_waddr = r_bp + r_size - 32'd8;
                w_wdata = r_size;
                n_state = ST_MG_DN;
            end
            // Add the size of the preceding block.
            ST_MB_1: begin
                w_raddr = r_bp - w_d - 32'd4;
                n_state = ST_MB_2;
            end
            ST_MB_2: begin
                n_size  = w_sum;
                w_raddr = r_bp - 32'd4;
                n_state = r_na ? ST_MC_1 : ST_MD_1;
            end
            // Merge with the preceding block only.
            ST_MC_1: begin
                w_we    = 1'b1;
                w_waddr = r_bp + w_d - 32'd8;
                w_wdata = r_size;
                n_state = ST_MC_2;
            end
            ST_MC_2: begin
                w_raddr = r_bp - 32'd8;
                n_state = ST_MC_3;
            end
            ST_MC_3: begin
                w_we    = 1'b1;
                w_waddr = r_bp - w_d - 32'd4;
                w_wdata = r_size;
                n_state = ST_MP_0;
            end
            // Merge with both neighbors.
            ST_MD_1: begin
                n_t     = r_bp + w_d;
                w_raddr = r_bp + w_d - 32'd4;
                n_state = ST_MD_2;
            end
            ST_MD_2: begin
                w_raddr = w_tnext - 32'd8;
                n_state = ST_MD_3;
            end
            ST_MD_3: begin
                n_size  = w_sum;
                w_raddr = r_bp - 32'd8;
                n_state = ST_MD_4;
            end
            ST_MD_4: begin
                w_we    = 1'b1;
                w_waddr = r_bp - w_d - 32'd4;
                w_wdata = r_size;
                n_state = ST_MD_5;
            end
            ST_MD_5: begin
                w_raddr = r_bp - 32'd4;
                n_state = ST_MD_6;
            end
            ST_MD_6: begin
                n_t     = r_bp + w_d;
                w_raddr = r_bp + w_d - 32'd4;
                n_state = ST_MD_7;
            end
            ST_MD_7: begin
                w_we    = 1'b1;
                w_waddr = w_tnext - 32'd8;
                w_wdata = r_size;
                n_state = ST_MP_0;
            end
            // Step back to the preceding block, which now heads the merge.
            ST_MP_0: begin
                w_raddr = r_bp - 32'd8;
                n_state = ST_MP_1;
            end
            ST_MP_1: begin
                n_bp    = r_bp - w_d;
                n_state = ST_MG_DN;
            end
            ST_MG_DN: begin
                n_rover = r_bp;
                if (r_free) begin
                    n_res.granted     = 1'b1;
                    n_res.result_addr = 16'd0;
                    n_state           = ST_RES;
                end else begin
                    n_state = ST_PL_0;
                end
            end
            // Walk from the rover to the end of the heap, one tag per cycle.
            ST_S1_0: begin
                n_n     = '0;
                w_raddr = r_rover - 32'd4;
                n_state = ST_S1_1;
            end
            ST_S1_1: begin
                n_t     = r_rover + w_d;
                w_raddr = r_rover + w_d - 32'd4;
                n_state = ST_S1_2;
            end
            ST_S1_2: begin
                if (w_walk_end || w_d == 32'd0) begin
                    n_state = ST_S2_0;
                end else if (!w_a && w_d >= r_asize) begin
                    n_bp    = r_t;
                    n_state = ST_PL_0;
                end else begin
                    n_n     = r_n + CNT_W'(1);
                    n_t     = w_tnext;
                    w_raddr = w_tnext - 32'd4;
                end
            end
            // Wrap round: walk from the prologue up to the rover.
            ST_S2_0: begin
                n_n  = '0;
                n_bp = bth_pkg::LIST_START;
                if (r_rover == bth_pkg::LIST_START) begin
                    n_state = ST_GR_0;
                end else begin
                    w_raddr = bth_pkg::LIST_START - 32'd4;
                    n_state = ST_S2_1;
                end
            end
            ST_S2_1: begin
                n_bp    = r_bp + w_d;
                n_n     = r_n + CNT_W'(1);
                w_raddr = r_bp + w_d - 32'd4;
                n_state = ST_S2_2;
            end
            ST_S2_2: begin
                if (!w_a && w_d >= r_asize) begin
                    n_state = ST_PL_0;
                end else if (w_walk_end || r_bp == r_rover) begin
                    n_state = ST_GR_0;
                end else begin
                    n_bp    = r_bp + w_d;
                    n_n     = r_n + CNT_W'(1);
                    w_raddr = r_bp + w_d - 32'd4;
                end
            end
            // Grow the break and lay down a new free block.
            ST_GR_0: begin
                if (w_grow > w_limit || r_brk > w_limit - w_grow) begin
                    n_res   = '0;
                    n_state = ST_RES;
                end else begin
                    n_size  = w_grow;
                    n_bp    = r_brk;
                    n_brk   = r_brk + w_grow;
                    n_free  = 1'b0;
                    n_state = ST_GR_1;
                end
            end
            ST_GR_1: begin
                w_we    = 1'b1;
                w_waddr = r_bp - 32'd4;
                w_wdata = r_size;
                n_state = ST_GR_2;
            end
            ST_GR_2: begin
                w_we    = 1'b1;
                w_waddr = r_bp + r_size - 32'd8;
                w_wdata = r_size;
                n_state = ST_GR_3;
            end
            ST_GR_3: begin
                w_we    = 1'b1;
                w_waddr = r_bp + r_size - 32'd4;
                w_wdata = bth_pkg::TAG_ALLOC;
                n_state = ST_MG_0;
            end
            // Place the block, splitting off the remainder when large enough.
            ST_PL_0: begin
                w_raddr = r_bp - 32'd4;
                n_state = ST_PL_1;
            end
            ST_PL_1: begin
                w_we    = 1'b1;
                w_waddr = r_bp - 32'd4;
                n_size  = w_d;
                if (w_d >= r_asize && w_d - r_asize >= bth_pkg::MIN_BLOCK) begin
                    w_wdata = r_asize | bth_pkg::TAG_ALLOC;
                    n_state = ST_PL_2;
                end else begin
                    w_wdata = w_d | bth_pkg::TAG_ALLOC;
                    n_state = ST_PL_5;
                end
            end
            ST_PL_2: begin
                w_we    = 1'b1;
                w_waddr = r_bp + r_asize - 32'd8;
                w_wdata = r_asize | bth_pkg::TAG_ALLOC;
                n_state = ST_PL_3;
            end
            ST_PL_3: begin
                w_we    = 1'b1;
                w_waddr = r_bp + r_asize - 32'd4;
                w_wdata = r_size - r_asize;
                n_state = ST_PL_4;
            end
            ST_PL_4: begin
                w_we              = 1'b1;
                w_waddr           = r_bp + r_size - 32'd8;
                w_wdata           = r_size - r_asize;
                n_rover           = r_bp;
                n_res.granted     = 1'b1;
                n_res.result_addr = r_bp[15:0];
                n_state           = ST_RES;
            end
            ST_PL_5: begin
                w_we              = 1'b1;
                w_waddr           = r_bp + r_size - 32'd8;
                w_wdata           = r_size | bth_pkg::TAG_ALLOC;
                n_rover           = r_bp;
                n_res.granted     = 1'b1;
                n_res.result_addr = r_bp[15:0];
                n_state           = ST_RES;
            end
            // Hand the result to the output register.
            ST_RES: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
            r_rover <= 32'(ROVER0);
            r_brk   <= 32'(BRK0);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_rover <= n_rover;
            r_brk   <= n_brk;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_bp    <= n_bp;
        r_t     <= n_t;
        r_size  <= n_size;
        r_asize <= n_asize;
        r_n     <= n_n;
        r_pa    <= n_pa;
        r_na    <= n_na;
        r_free  <= n_free;
        r_res   <= n_res;
    end

    assign o_res       = r_res;
    assign o_mem_we    = w_we;
    assign o_mem_wdata = w_wdata;
    assign o_mem_waddr = (r_state == ST_INIT) ? r_clr : w_waddr[ADDR_W+1:2];
    assign o_mem_raddr = w_raddr[ADDR_W+1:2];

endmodule

>>> rtl/core/boundary_tag_heap_allocator.sv
// Allocate: a next-fit walk from the rover to the end of the heap, then from the prologue
// back to the rover, looks for a free block that fits and places it whole or split. If
// none fits, the heap grows and coalesces, or the request fails at the limit. A zero-size
// allocate is refused without a walk; a free coalesces with its neighbors. One request is in
// work at a time; the walk over the single read port sets the rate, and a result register
// lets the next request in. After reset a clearing pass blocks requests; config is always taken.
`timescale 1ns / 1ps

module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // req_size [16:0], block_addr [32:17], zeros
    input  logic [0:0]  s_axis_tuser,   // req_type [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result_addr [15:0]
    output logic [0:0]  m_axis_tuser,   // granted [0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(HEAP_BYTES) - 2;

    logic [16:0]       r_limit;
    logic              r_out_valid;
    bth_pkg::t_result  r_out;
    bth_pkg::t_req     w_req;
    bth_pkg::t_result  w_res;
    logic              w_res_valid;
    logic              w_res_ready;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [31:0]       w_mem_wdata;
    logic [ADDR_W-1:0] w_mem_raddr;
    logic [31:0]       w_mem_rdata;

    // Heap limit register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bth_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Unpack the input transaction.
    assign w_req.req_type   = s_axis_tuser[0];
    assign w_req.req_size   = s_axis_tdata[16:0];
    assign w_req.block_addr = s_axis_tdata[32:17];

    bth_ctrl #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    bth_heap_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Output register between the controller and the result stream.
    assign w_res_ready = !r_out_valid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.result_addr;
    assign m_axis_tuser[0] = r_out.granted;

    // A failed allocate never reports an address.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("failed allocate carries a nonzero address");

    // The controller is busy in the cycle after it takes a request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one is in work");

    // A result handed over shows up in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res_ready |=>
            m_axis_tvalid && m_axis_tdata == $past(w_res.result_addr))
        else $error("result lost between controller and output register");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the boundary-tag heap allocator.
// It predicts each allocate and free result with its own heap model and
// compares the outputs. It needs bth_pkg and boundary_tag_heap_allocator.
`timescale 1ns / 1ps

// Holds the expected heap state and the results still to arrive.
class alloc_scoreboard;
    localparam int STORE_WORDS = 16384;
    localparam int WALK_LIMIT  = 65536 / 8 + 2;
    localparam int CHUNK       = 4096;

    logic [31:0] heap_words[STORE_WORDS];
    logic [31:0] brk;
    logic [31:0] rover;
    logic [31:0] limit_bytes;
    bth_pkg::t_result expected_grants[$];
    int          mismatches;

    function new();
        logic [31:0] blk;
        foreach (heap_words[i]) heap_words[i] = '0;
        wr(4, 9);
        wr(8, 9);
        wr(12, 1);
        rover       = bth_pkg::LIST_START;
        brk         = 16;
        limit_bytes = 65536;
        mismatches  = 0;
        void'(grow(CHUNK, blk));
    endfunction

    function logic [31:0] rd(logic [31:0] a);
        return heap_words[(a >> 2) % STORE_WORDS];
    endfunction

    function void wr(logic [31:0] a, logic [31:0] v);
        heap_words[(a >> 2) % STORE_WORDS] = v;
    endfunction

    function logic [31:0] size_at(logic [31:0] a);
        return rd(a) & bth_pkg::SIZE_MASK;
    endfunction

    function logic alloc_at(logic [31:0] a);
        logic [31:0] word;
        word = rd(a);
        return word[0];
    endfunction

    function logic [31:0] nxt(logic [31:0] bp);
        return bp + size_at(bp - 4);
    endfunction

    function logic [31:0] prv(logic [31:0] bp);
        return bp - size_at(bp - 8);
    endfunction

    function logic [31:0] ftr(logic [31:0] bp);
        return bp + size_at(bp - 4) - 8;
    endfunction

    // Merges a free block with its free neighbors and moves the rover there.
    function logic [31:0] coalesce(logic [31:0] bp);
        logic        pa, na;
        logic [31:0] sz;
        pa = alloc_at(ftr(prv(bp)));
        na = alloc_at(nxt(bp) - 4);
        sz = size_at(bp - 4);
        if (pa && !na) begin
            sz = sz + size_at(nxt(bp) - 4);
            wr(bp - 4, sz);
            wr(ftr(bp), sz);
        end else if (!pa && na) begin
            sz = sz + size_at(prv(bp) - 4);
            wr(ftr(bp), sz);
            wr(prv(bp) - 4, sz);
            bp = prv(bp);
        end else if (!pa && !na) begin
            sz = sz + size_at(prv(bp) - 4) + size_at(ftr(nxt(bp)));
            wr(prv(bp) - 4, sz);
            wr(ftr(nxt(bp)), sz);
            bp = prv(bp);
        end
        rover = bp;
        return bp;
    endfunction

    function bit fits(logic [31:0] bp, logic [31:0] asize);
        return !alloc_at(bp - 4) && size_at(bp - 4) >= asize;
    endfunction

    // Next-fit walk: rover to the end, then from the prologue back to the rover.
    function bit search(logic [31:0] asize, output logic [31:0] found);
        logic [31:0] bp;
        found = 0;
        bp = rover;
        for (int n = 0; n < WALK_LIMIT && size_at(nxt(bp) - 4) > 0; n++) begin
            bp = nxt(bp);
            if (fits(bp, asize)) begin
                found = bp;
                return 1;
            end
        end
        bp = bth_pkg::LIST_START;
        for (int n = 0; n < WALK_LIMIT && bp != rover; n++) begin
            bp = nxt(bp);
            if (fits(bp, asize)) begin
                found = bp;
                return 1;
            end
        end
        return 0;
    endfunction

    function void place(logic [31:0] bp, logic [31:0] asize);
        logic [31:0] sz;
        sz = size_at(bp - 4);
        if (sz >= asize && sz - asize >= bth_pkg::MIN_BLOCK) begin
            wr(bp - 4, asize | 1);
            wr(ftr(bp), asize | 1);
            wr(nxt(bp) - 4, sz - asize);
            wr(ftr(nxt(bp)), sz - asize);
        end else begin
            wr(bp - 4, sz | 1);
            wr(ftr(bp), sz | 1);
        end
        rover = bp;
    endfunction

    function bit grow(logic [31:0] bytes, output logic [31:0] blk);
        logic [31:0] sz, lim, bp;
        blk = 0;
        sz  = (bytes + 7) & bth_pkg::SIZE_MASK;
        lim = (limit_bytes < 65536) ? limit_bytes : 65536;
        bp  = brk;
        if (sz > lim || bp > lim - sz) return 0;
        brk = bp + sz;
        wr(bp - 4, sz);
        wr(ftr(bp), sz);
        wr(nxt(bp) - 4, 1);
        blk = coalesce(bp);
        return 1;
    endfunction

    function void set_limit(logic [16:0] value);
        limit_bytes = {15'd0, value};
    endfunction

    // Notes an accepted request; returns the expected result.
    function bth_pkg::t_result note_request(logic kind, logic [16:0] req,
                                            logic [15:0] addr);
        bth_pkg::t_result res;
        logic [31:0] asize, bp, ext, sz;
        bit ok;
        ok = 0;
        bp = 0;
        if (kind == bth_pkg::REQ_FREE) begin
            sz = size_at({16'd0, addr} - 4);
            wr({16'd0, addr} - 4, sz);
            wr(ftr({16'd0, addr}), sz);
            void'(coalesce({16'd0, addr}));
            res.granted     = 1'b1;
            res.result_addr = '0;
        end else begin
            if (req != 0) begin
                asize = (req <= 8) ? 32'd16 : 8 * ((req + 15) / 8);
                ok = search(asize, bp);
                if (!ok) begin
                    ext = (asize > CHUNK) ? asize : CHUNK;
                    ok  = grow(ext, bp);
                end
                if (ok) place(bp, asize);
            end
            res.granted     = ok;
            res.result_addr = ok ? bp[15:0] : 16'd0;
        end
        expected_grants.push_back(res);
        return res;
    endfunction

    // Compares one delivered result with the oldest expectation.
    function void check_result(logic [15:0] addr, logic granted);
        bth_pkg::t_result exp_res;
        if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: addr %0d granted %0d", addr, granted);
            return;
        end
        exp_res = expected_grants.pop_front();
        if (exp_res.result_addr !== addr || exp_res.granted !== granted) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result mismatch: expected addr %0d granted %0d, got %0d %0d",
                         exp_res.result_addr, exp_res.granted, addr, granted);
        end
    endfunction
endclass

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data;

    alloc_scoreboard heap_sb;
    logic [15:0]     live_blocks[$];
    int              send_idle_pct;
    int              recv_idle_pct;
    int              quiet_cycles;

    boundary_tag_heap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver stalls at random and checks every delivered result.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            heap_sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one request and predicts its result once it is taken.
    task automatic send_request(input logic kind, input logic [16:0] req,
                                input logic [15:0] addr);
        bth_pkg::t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, addr, req};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = heap_sb.note_request(kind, req, addr);
        if (kind == bth_pkg::REQ_ALLOC && res.granted) live_blocks.push_back(res.result_addr);
    endtask

    // Frees a random live block, or allocates when none is held.
    task automatic free_random_block();
        int pick;
        logic [15:0] addr;
        if (live_blocks.size() == 0) begin
            send_request(bth_pkg::REQ_ALLOC, 17'd24, 16'd0);
        end else begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            addr = live_blocks[pick];
            live_blocks.delete(pick);
            send_request(bth_pkg::REQ_FREE, 17'($urandom), addr);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (heap_sb.expected_grants.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [16:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        heap_sb.set_limit(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small allocations mixed with frees of live blocks.
    task automatic random_requests(input int count);
        int roll;
        logic [16:0] req;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                free_random_block();
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70)      req = 17'($urandom_range(1, 200));
                else if (roll < 90) req = 17'($urandom_range(201, 4000));
                else if (roll < 98) req = 17'($urandom_range(4001, 20000));
                else                req = 17'($urandom);
                send_request(bth_pkg::REQ_ALLOC, req, 16'($urandom));
            end
        end
    endtask

    initial begin
        heap_sb       = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(17'd65536);

        // Directed part: zero size, minimum blocks, exact fit, growth, failure.
        send_request(bth_pkg::REQ_ALLOC, 17'd0, 16'hFFFF);
        send_request(bth_pkg::REQ_ALLOC, 17'd1, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'd8, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'd9, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'h1_0000, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'h1_FFFF, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'd4000, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'd5000, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'd30000, 16'd0);
        // Frees of randomly picked live blocks, which may merge with their neighbors.
        for (int n = 0; n < 6; n++) free_random_block();
        send_request(bth_pkg::REQ_ALLOC, 17'd60000, 16'd0);

        // A limit of 32 bytes: no growth can succeed.
        write_limit(17'd32);
        random_requests(40);

        write_limit(17'd65536);
        send_idle_pct = 32;
        recv_idle_pct = 62;
        random_requests(580);

        write_limit(17'd24000);
        send_idle_pct = 62;
        recv_idle_pct = 32;
        random_requests(560);

        write_limit(17'd65536);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(550);

        // Frees at arbitrary addresses, taken without any check.
        send_request(bth_pkg::REQ_FREE, 17'h1_FFFF, 16'hFFFF);
        send_request(bth_pkg::REQ_FREE, 17'd0, 16'h0003);
        send_request(bth_pkg::REQ_FREE, 17'd0, 16'h8000);
        send_request(bth_pkg::REQ_ALLOC, 17'd40, 16'd0);
        send_request(bth_pkg::REQ_ALLOC, 17'd3000, 16'd0);

        wait_idle();
        if (heap_sb.mismatches == 0 && heap_sb.expected_grants.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/bth_pkg.sv
rtl/core/bth_heap_ram.sv
rtl/core/bth_ctrl.sv
rtl/core/boundary_tag_heap_allocator.sv
test/testbench.sv
